[rtl/hap_pkg.sv]
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types, constants and mask functions for the handle allocator.
// ----------------------------------------------------------------------------
package hap_pkg;

   localparam int MAP_DEPTH = 256;
   localparam int HANDLE_W  = 8;
   localparam int CMD_W     = 2;
   localparam logic [HANDLE_W-1:0] LAST_RESORT = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CHECK = 2'd2
   } cmd_type;

   // one update of the used map per beat; set and clear never coincide
   typedef struct packed {
      logic                set;
      logic                clr;
      logic [HANDLE_W-1:0] idx;
   } map_wr_type;

   // handles 1, 2, 4 .. 128
   function automatic logic [MAP_DEPTH-1:0] pow2_mask();
      logic [MAP_DEPTH-1:0] m;
      m = '0;
      for (int i = 0; i < HANDLE_W; i++) begin
         m[1 << i] = 1'b1;
      end
      return m;
   endfunction

   // handles that are not a power of two, without 0 and the last resort
   function automatic logic [MAP_DEPTH-1:0] non_pow2_mask();
      logic [MAP_DEPTH-1:0] m;
      m = ~pow2_mask();
      m[0] = 1'b0;
      m[LAST_RESORT] = 1'b0;
      return m;
   endfunction

   // lowest set bit as an index, independent or over an isolated one-hot
   function automatic logic [HANDLE_W-1:0] lowest_index(input logic [MAP_DEPTH-1:0] v);
      logic [MAP_DEPTH-1:0] oh;
      logic [HANDLE_W-1:0]  idx;
      oh  = v & (~v + MAP_DEPTH'(1));
      idx = '0;
      for (int i = 0; i < MAP_DEPTH; i++) begin
         if (oh[i]) begin
            idx = idx | HANDLE_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/hap_map.sv]
// ----------------------------------------------------------------------------
// hap_map
// Used flag per handle, one set or clear per cycle, all clear at reset.
// ----------------------------------------------------------------------------
module hap_map #(
   parameter int NUM_HANDLES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hap_pkg::map_wr_type              wr,
   output logic [hap_pkg::MAP_DEPTH-1:0]    used_ext
);
   import hap_pkg::*;

   logic [NUM_HANDLES-1:0] map_ff;
   logic [NUM_HANDLES-1:0] map_in;

   always_comb begin
      map_in = map_ff;
      for (int i = 0; i < NUM_HANDLES; i++) begin
         if (wr.idx == HANDLE_W'(i)) begin
            if (wr.set) begin
               map_in[i] = 1'b1;
            end
            if (wr.clr) begin
               map_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   // handles that do not exist read as not in use
   always_comb begin
      used_ext = '0;
      used_ext[NUM_HANDLES-1:0] = map_ff;
   end

endmodule

[rtl/hap_pick.sv]
// ----------------------------------------------------------------------------
// hap_pick
// Ordered searches over the free map and the choice between them.
// ----------------------------------------------------------------------------
module hap_pick (
   input  logic [hap_pkg::MAP_DEPTH-1:0] free_ext,
   input  logic                          for_io,
   input  logic                          safe_mode,
   output logic                          found,
   output logic [hap_pkg::HANDLE_W-1:0]  handle
);
   import hap_pkg::*;

   localparam logic [MAP_DEPTH-1:0] PowMask = pow2_mask();
   localparam logic [MAP_DEPTH-1:0] NonMask = non_pow2_mask();

   logic [MAP_DEPTH-1:0] pow_vec;
   logic [MAP_DEPTH-1:0] non_vec;
   logic                 pow_hit;
   logic                 non_hit;
   logic                 lr_hit;
   logic [HANDLE_W-1:0]  pow_h;
   logic [HANDLE_W-1:0]  non_h;

   assign pow_vec = free_ext & PowMask;
   assign non_vec = free_ext & NonMask;
   assign pow_hit = |pow_vec;
   assign non_hit = |non_vec;
   assign lr_hit  = free_ext[LAST_RESORT] & ~safe_mode;
   assign pow_h   = lowest_index(pow_vec);
   assign non_h   = lowest_index(non_vec);

   always_comb begin
      found  = 1'b1;
      handle = LAST_RESORT;
      if (for_io) begin
         if (pow_hit) begin
            handle = pow_h;
         end else if (non_hit && !safe_mode) begin
            handle = non_h;
         end else if (!lr_hit) begin
            found  = 1'b0;
            handle = '0;
         end
      end else begin
         if (non_hit) begin
            handle = non_h;
         end else if (pow_hit) begin
            handle = pow_h;
         end else if (!lr_hit) begin
            found  = 1'b0;
            handle = '0;
         end
      end
   end

endmodule

[rtl/handle_allocator_pow2_pref_top.sv]
// ----------------------------------------------------------------------------
// handle_allocator_pow2_pref_top
// Handle allocator with power-of-two preference for I/O handles.
//
//   channel   ports                                   handshake
//   request   req_cmd, req_for_io, req_handle_in      start && !busy
//   response  rsp_handle_out, rsp_status              rsp_valid, one cycle
//   csr       csr_wr_data                             csr_wr_en
//
// One command per cycle. A request beat is registered, the map lookup and
// update happen in the next cycle, and the response is registered from the
// lookup and driven on the ports from the rsp_*_ff registers. busy
// stays low: the used map is updated in the same cycle it is searched, so
// back-to-back commands see each other. The receiver cannot stall.
// Synchronous reset clears the map and sets safe mode.
// ----------------------------------------------------------------------------
module handle_allocator_pow2_pref_top #(
   parameter int NUM_HANDLES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hap_pkg::CMD_W-1:0]     req_cmd,
   input  logic                          req_for_io,
   input  logic [hap_pkg::HANDLE_W-1:0]  req_handle_in,
   output logic                          rsp_valid,
   output logic [hap_pkg::HANDLE_W-1:0]  rsp_handle_out,
   output logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import hap_pkg::*;

   logic                 req_valid_ff;
   logic [CMD_W-1:0]     req_cmd_ff;
   logic                 req_io_ff;
   logic [HANDLE_W-1:0]  req_handle_ff;
   logic                 safe_ff;
   logic                 rsp_valid_ff;
   logic [HANDLE_W-1:0]  rsp_handle_ff;
   logic                 rsp_status_ff;

   logic [HANDLE_W-1:0]  rsp_handle_in;
   logic                 rsp_status_in;
   map_wr_type           wr;
   logic [MAP_DEPTH-1:0] used_ext;
   logic [MAP_DEPTH-1:0] exist_mask;
   logic [MAP_DEPTH-1:0] free_ext;
   logic                 pick_found;
   logic [HANDLE_W-1:0]  pick_handle;
   logic                 used_hit;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         safe_ff      <= 1'b1;
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
         if (csr_wr_en) begin
            safe_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff    <= req_cmd;
      req_io_ff     <= req_for_io;
      req_handle_ff <= req_handle_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   hap_map #(
      .NUM_HANDLES (NUM_HANDLES)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .used_ext (used_ext)
   );

   // handles 1 .. NUM_HANDLES-1 exist
   always_comb begin
      exist_mask = '0;
      for (int i = 1; i < NUM_HANDLES; i++) begin
         exist_mask[i] = 1'b1;
      end
   end

   assign free_ext = ~used_ext & exist_mask;

   hap_pick u_pick (
      .free_ext  (free_ext),
      .for_io    (req_io_ff),
      .safe_mode (safe_ff),
      .found     (pick_found),
      .handle    (pick_handle)
   );

   assign used_hit = (req_handle_ff != '0) && used_ext[req_handle_ff];

   always_comb begin
      rsp_handle_in = '0;
      rsp_status_in = 1'b1;
      wr            = '0;
      if (req_valid_ff) begin
         unique case (cmd_type'(req_cmd_ff))
            CMD_ALLOC: begin
               if (pick_found) begin
                  rsp_handle_in = pick_handle;
                  rsp_status_in = 1'b0;
                  wr.set        = 1'b1;
                  wr.idx        = pick_handle;
               end
            end
            CMD_FREE: begin
               if (used_hit) begin
                  rsp_handle_in = req_handle_ff;
                  rsp_status_in = 1'b0;
                  wr.clr        = 1'b1;
                  wr.idx        = req_handle_ff;
               end
            end
            CMD_CHECK: begin
               if (used_hit) begin
                  rsp_handle_in = req_handle_ff;
                  rsp_status_in = 1'b0;
               end
            end
            default: begin
               rsp_status_in = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
